// ===== hw/rtl/srgb8_pkg.sv =====
// Shared types, constants and elaboration-time functions for the linear to sRGB converter.
// No dependencies; used by srgb8_lane, the top level and the testbench, but not by srgb8_decode.
`default_nettype none

package srgb8_pkg;

  typedef struct packed {
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
    logic [31:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  localparam int CoefWidth    = 18;
  localparam int ColWidth     = 3 * CoefWidth;
  localparam int CfgIdxWidth  = 4;
  localparam int EncWidth     = 17;
  localparam int KneeQ26      = 210104;
  localparam int LinSlopeQ16  = 846725;
  localparam int EncOne       = 65536;
  localparam int CurveOffset  = 57671680;
  localparam int CurveDiv     = 16000;

  localparam logic [CfgIdxWidth-1:0] RegColRed   = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegColGreen = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegColBlue  = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegLumOnly  = 4'd3;

  localparam logic [ColWidth-1:0] ColRedReset   = 54'd16384;
  localparam logic [ColWidth-1:0] ColGreenReset = 54'd4294967296;
  localparam logic [ColWidth-1:0] ColBlueReset  = 54'd1125899906842624;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 30; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] icbrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 20; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t * t <= v) r = t;
    end
    return r;
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [EncWidth-1:0] curve_entry(input int unsigned n,
                                                     input int unsigned i);
    logic [63:0] u;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] p;
    logic [63:0] nn;
    logic [63:0] e;
    u = udiv(64'(i) << 30, 64'(n));
    a = isqrt(u << 30);
    b = isqrt(a << 30);
    c = icbrt((b >> 10) << 40);
    p = c;
    for (int k = 0; k < 4; k++) p = (p * c) >> 20;
    nn = p * 64'd1055 + 64'd8000;
    e = (nn < 64'(CurveOffset)) ? 64'd0 : (nn - 64'(CurveOffset)) / CurveDiv;
    if (e > 64'(EncOne)) e = 64'(EncOne);
    return e[EncWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srgb8_decode.sv =====
// Registered binary32 to signed fixed-point decode for one sample lane.
// Depends on nothing but its parameter.
`default_nettype none

module srgb8_decode #(
  parameter int F = 16,
  parameter int W = 16 + F
) (
  input  wire logic                clk,
  input  wire logic [31:0]         bits,
  output      logic signed [W-1:0] q
);

  localparam logic [63:0] MaxV = (64'd1 << (W - 1)) - 64'd1;

  logic [7:0]         expo;
  logic [23:0]        sig;
  logic signed [9:0]  sft;
  logic [9:0]         rr;
  logic [63:0]        mag;
  logic [W-2:0]       mag_sat;
  logic signed [W-1:0] q_next;

  always_comb begin
    expo = bits[30:23];
    sig  = {(expo != 8'd0), bits[22:0]};
    sft  = $signed({2'b00, (expo == 8'd0) ? 8'd1 : expo}) - 10'sd150 + 10'(F);
    rr   = 10'(-sft);
    mag  = '0;
    if (sft >= 0) begin
      if (sft > 10'sd39) mag = MaxV + 64'd1;
      else mag = {40'd0, sig} << sft[5:0];
    end else if (rr < 10'd40) begin
      mag = ({40'd0, sig} + (64'd1 << (rr[5:0] - 6'd1))) >> rr[5:0];
    end
    mag_sat = (mag > MaxV) ? MaxV[W-2:0] : mag[W-2:0];
    if (expo == 8'hFF) q_next = '0;
    else if (bits[31]) q_next = -$signed({1'b0, mag_sat});
    else q_next = $signed({1'b0, mag_sat});
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srgb8_lane.sv =====
// One colour lane: matrix row, clamp, sRGB encode with interpolated curve ROM, 8-bit round.
// Depends on srgb8_pkg. Five register stages from decoded samples to code.
`default_nettype none

module srgb8_lane #(
  parameter int F = 16,
  parameter int N = 1024,
  parameter int W = 16 + F
) (
  input  wire logic                            clk,
  input  wire logic [srgb8_pkg::ColWidth-1:0]  col,
  input  wire logic signed [W-1:0]             r,
  input  wire logic signed [W-1:0]             g,
  input  wire logic signed [W-1:0]             b,
  output      logic [7:0]                      code
);

  localparam int NW = $clog2(N + 1);
  localparam int EW = srgb8_pkg::EncWidth;
  localparam int KneeX = srgb8_pkg::KneeQ26 >> (26 - F);

  logic [EW-1:0] curve_rom [0:N];

  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam logic [EW-1:0] Entry = srgb8_pkg::curve_entry(N, k);
    assign curve_rom[k] = Entry;
  end

  // matrix products
  logic signed [W+17:0] p0, p1, p2;

  always_ff @(posedge clk) begin
    p0 <= $signed(col[17:0]) * r;
    p1 <= $signed(col[35:18]) * g;
    p2 <= $signed(col[53:36]) * b;
  end

  // sum, round, clamp to [0, one]
  logic signed [W+19:0] sum;
  logic signed [W+19:0] qs;
  logic [W+18:0]        qm;
  logic [F:0]           x_next;
  logic [F:0]           x;

  always_comb begin
    sum = (W+20)'(p0) + (W+20)'(p1) + (W+20)'(p2) + (W+20)'(8192);
    qs  = sum >>> 14;
    qm  = qs[W+18:0];
    if (sum[W+19]) x_next = '0;
    else if (qm > (W+19)'(1 << F)) x_next = (F+1)'(1 << F);
    else x_next = qm[F:0];
  end

  always_ff @(posedge clk) begin
    x <= x_next;
  end

  // table index, linear segment
  logic [F+NW:0]   pidx;
  logic [NW-1:0]   idx;
  logic [NW-1:0]   idx_up;
  logic [F+20:0]   lin_prod;
  logic [EW-1:0]   lo, hi, lin_y;
  logic [F-1:0]    frac;
  logic            is_lin;

  always_comb begin
    pidx     = (F+NW+1)'(x) * (F+NW+1)'(N);
    idx      = pidx[F+NW-1:F];
    idx_up   = (idx == NW'(N)) ? idx : idx + NW'(1);
    lin_prod = (F+21)'(x) * (F+21)'(srgb8_pkg::LinSlopeQ16) + (F+21)'(1 << (F - 1));
  end

  always_ff @(posedge clk) begin
    lo     <= curve_rom[idx];
    hi     <= curve_rom[idx_up];
    frac   <= pidx[F-1:0];
    is_lin <= (x <= (F+1)'(KneeX));
    lin_y  <= EW'(lin_prod >> F);
  end

  // interpolation
  logic [F+17:0] ip;
  logic [EW-1:0] y;

  always_comb begin
    ip = (F+18)'(hi - lo) * (F+18)'(frac) + (F+18)'(1 << (F - 1));
  end

  always_ff @(posedge clk) begin
    y <= is_lin ? lin_y : lo + EW'(ip >> F);
  end

  // round to eight bits
  logic [24:0] y255;

  assign y255 = 25'(y) * 25'd255 + 25'd32768;

  always_ff @(posedge clk) begin
    code <= y255[23:16];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_to_srgb8_pixel_convert.sv =====
// Top level: decode lanes, three colour lanes, alpha path and result merge.
// Depends on srgb8_pkg, srgb8_decode and srgb8_lane.
`default_nettype none

// Converts one linear binary32 RGBA pixel per clock, while busy is low, to 8-bit sRGB. A
// transaction started with start is answered by a one-cycle done strobe with the result;
// the receiver cannot stall, and the pipeline of decode, multiply, sum, curve ROM read,
// interpolate and round stages takes a new pixel every cycle while busy is low. busy is high
// only during and just after reset. Configuration writes are taken at any time; issue them
// while no pixel is in flight.
module linear_to_srgb8_pixel_convert #(
  parameter int GAMMA_TABLE_ENTRIES = 1024,
  parameter int VALUE_FRACTION_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire srgb8_pkg::pix_in_t                    pixel_in,
  output      logic                                  done,
  output      srgb8_pkg::pix_out_t                   result,
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [srgb8_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire logic [srgb8_pkg::ColWidth-1:0]        cfg_data
);

  localparam int F = VALUE_FRACTION_BITS;
  localparam int W = 16 + F;

  logic [srgb8_pkg::ColWidth-1:0] col_red, col_green, col_blue;
  logic                           lum_only;
  logic [5:0]                     vld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_red   <= srgb8_pkg::ColRedReset;
      col_green <= srgb8_pkg::ColGreenReset;
      col_blue  <= srgb8_pkg::ColBlueReset;
      lum_only  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srgb8_pkg::RegColRed:   col_red   <= cfg_data;
        srgb8_pkg::RegColGreen: col_green <= cfg_data;
        srgb8_pkg::RegColBlue:  col_blue  <= cfg_data;
        srgb8_pkg::RegLumOnly:  lum_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[4:0], start && !busy};
    end
  end

  assign done = vld[5];

  // decode lanes
  logic signed [W-1:0] dr, dg, db, da;

  srgb8_decode #(.F(F), .W(W)) u_dec_r (.clk(clk), .bits(pixel_in.red_in),   .q(dr));
  srgb8_decode #(.F(F), .W(W)) u_dec_g (.clk(clk), .bits(pixel_in.green_in), .q(dg));
  srgb8_decode #(.F(F), .W(W)) u_dec_b (.clk(clk), .bits(pixel_in.blue_in),  .q(db));
  srgb8_decode #(.F(F), .W(W)) u_dec_a (.clk(clk), .bits(pixel_in.alpha_in), .q(da));

  logic                lum_q;
  logic signed [W-1:0] g_sel, b_sel;

  always_ff @(posedge clk) begin
    lum_q <= lum_only;
  end

  assign g_sel = lum_q ? dr : dg;
  assign b_sel = lum_q ? dr : db;

  // colour lanes
  logic [7:0] code_r, code_g, code_b;

  srgb8_lane #(.F(F), .N(GAMMA_TABLE_ENTRIES), .W(W)) u_lane_r (
    .clk(clk), .col(col_red), .r(dr), .g(g_sel), .b(b_sel), .code(code_r)
  );
  srgb8_lane #(.F(F), .N(GAMMA_TABLE_ENTRIES), .W(W)) u_lane_g (
    .clk(clk), .col(col_green), .r(dr), .g(g_sel), .b(b_sel), .code(code_g)
  );
  srgb8_lane #(.F(F), .N(GAMMA_TABLE_ENTRIES), .W(W)) u_lane_b (
    .clk(clk), .col(col_blue), .r(dr), .g(g_sel), .b(b_sel), .code(code_b)
  );

  // alpha: clamp, scale, round, then delay to match the colour lanes
  logic [F:0]    ax;
  logic [F+8:0]  aprod;
  logic [7:0]    alpha_dly [0:4];

  always_comb begin
    if (da[W-1]) ax = '0;
    else if (da > W'(1 << F)) ax = (F+1)'(1 << F);
    else ax = da[F:0];
    aprod = (F+9)'(ax) * (F+9)'(255) + (F+9)'(1 << (F - 1));
  end

  always_ff @(posedge clk) begin
    alpha_dly[0] <= 8'(aprod >> F);
    alpha_dly[1] <= alpha_dly[0];
    alpha_dly[2] <= alpha_dly[1];
    alpha_dly[3] <= alpha_dly[2];
    alpha_dly[4] <= alpha_dly[3];
  end

  // merge
  always_comb begin
    result.red_out   = code_r;
    result.green_out = code_g;
    result.blue_out  = code_b;
    result.alpha_out = alpha_dly[4];
  end

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result strobe without a matching start transaction");

  a_start_enters: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> vld[0])
    else $error("accepted transaction not tracked in pipeline");

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe straight after reset");

  a_busy_clears: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy held outside reset");
`endif

endmodule

`default_nettype wire

// ===== sim/linear_to_srgb8_pixel_convert_tb.sv =====
// Self-checking testbench for linear_to_srgb8_pixel_convert: a directed table then random
// pixels, with an in-bench fixed-point model of decode, matrix, sRGB curve and alpha.
// Depends on srgb8_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

module linear_to_srgb8_pixel_convert_tb;

  localparam int   NumRandom = 1750;
  localparam int   Frac      = 16;
  localparam longint OneQ    = 64'sd1 << Frac;
  localparam longint MaxQ    = (64'sd1 << (15 + Frac)) - 1;
  localparam int   Entries   = 1024;
  localparam int   WatchLimit = 2000;
  localparam logic [srgb8_pkg::CfgIdxWidth-1:0] RegUnused = 4'd9;

  typedef struct {
    srgb8_pkg::pix_in_t  px;
    logic                known;
    srgb8_pkg::pix_out_t want;
  } row_t;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  srgb8_pkg::pix_in_t                pixel_in;
  logic                              done;
  srgb8_pkg::pix_out_t               result;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [srgb8_pkg::CfgIdxWidth-1:0] cfg_index;
  logic [srgb8_pkg::ColWidth-1:0]    cfg_data;

  logic [srgb8_pkg::ColWidth-1:0] col_red, col_green, col_blue;
  logic                           lum_only;
  longint                         gamma_curve [0:Entries];
  srgb8_pkg::pix_out_t            pixels_due [$];
  int                             mismatches;
  int                             idle_cycles;
  bit                             timed_out;

  linear_to_srgb8_pixel_convert u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel_in(pixel_in),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint root_sq(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int k = 30; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint root_cube(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int k = 20; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void build_gamma_curve();
    longint unsigned u, a, b, c, p, n, e;
    for (int i = 0; i <= Entries; i++) begin
      u = (longint'(i) << 30) / Entries;
      a = root_sq(u << 30);
      b = root_sq(a << 30);
      c = root_cube((b >> 10) << 40);
      p = c;
      for (int k = 0; k < 4; k++) p = (p * c) >> 20;
      n = p * 1055 + 8000;
      e = (n < 57671680) ? 0 : (n - 57671680) / 16000;
      if (e > srgb8_pkg::EncOne) e = srgb8_pkg::EncOne;
      gamma_curve[i] = e;
    end
  endfunction

  function automatic longint float_to_fixed(logic [31:0] bits);
    longint unsigned sig, mag;
    int              ex, s;
    ex  = int'(bits[30:23]);
    sig = 64'(bits[22:0]);
    if (ex == 255) return 0;
    if (ex != 0) sig |= 64'd1 << 23;
    else ex = 1;
    if (sig == 0) return 0;
    s = ex - 150 + Frac;
    if (s >= 0) mag = (s > 39) ? MaxQ + 1 : sig << s;
    else mag = (-s >= 40) ? 0 : (sig + (64'd1 << (-s - 1))) >> (-s);
    if (mag > MaxQ) mag = MaxQ;
    return bits[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint matrix_row(logic [srgb8_pkg::ColWidth-1:0] col, longint r,
                                        longint g, longint b);
    longint t, q;
    t = longint'($signed(col[17:0])) * r + longint'($signed(col[35:18])) * g
      + longint'($signed(col[53:36])) * b + 8192;
    q = t >>> 14;
    if (q > MaxQ) q = MaxQ;
    if (q < -MaxQ - 1) q = -MaxQ - 1;
    return q;
  endfunction

  function automatic logic [7:0] srgb_code(longint v);
    longint y, p, i, f;
    if (v < 0) v = 0;
    if (v > OneQ) v = OneQ;
    if ((v << (26 - Frac)) <= srgb8_pkg::KneeQ26) begin
      y = (v * srgb8_pkg::LinSlopeQ16 + (OneQ >> 1)) >> Frac;
    end else begin
      p = v * Entries;
      i = p >> Frac;
      f = p & (OneQ - 1);
      if (i >= Entries) y = gamma_curve[Entries];
      else y = gamma_curve[i]
             + (((gamma_curve[i+1] - gamma_curve[i]) * f + (OneQ >> 1)) >> Frac);
    end
    if (y > srgb8_pkg::EncOne) y = srgb8_pkg::EncOne;
    return 8'((y * 255 + 32768) >> 16);
  endfunction

  function automatic srgb8_pkg::pix_out_t convert_pixel(srgb8_pkg::pix_in_t px);
    longint              r, g, b, a;
    srgb8_pkg::pix_out_t o;
    r = float_to_fixed(px.red_in);
    g = lum_only ? r : float_to_fixed(px.green_in);
    b = lum_only ? r : float_to_fixed(px.blue_in);
    a = float_to_fixed(px.alpha_in);
    if (a < 0) a = 0;
    if (a > OneQ) a = OneQ;
    o.red_out   = srgb_code(matrix_row(col_red, r, g, b));
    o.green_out = srgb_code(matrix_row(col_green, r, g, b));
    o.blue_out  = srgb_code(matrix_row(col_blue, r, g, b));
    o.alpha_out = 8'((a * 255 + (OneQ >> 1)) >> Frac);
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else if (result !== pixels_due[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h, got %h", pixels_due[0], result);
        void'(pixels_due.pop_front());
      end else begin
        void'(pixels_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  task automatic wait_drained();
    start <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [srgb8_pkg::CfgIdxWidth-1:0] idx,
                           logic [srgb8_pkg::ColWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      srgb8_pkg::RegColRed:   col_red   = val;
      srgb8_pkg::RegColGreen: col_green = val;
      srgb8_pkg::RegColBlue:  col_blue  = val;
      srgb8_pkg::RegLumOnly:  lum_only  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(srgb8_pkg::pix_in_t px, logic known,
                            srgb8_pkg::pix_out_t want, bit gaps);
    int w;
    w = gaps ? int'($urandom_range(0, 17)) : 0;
    if (w != 0) begin
      start <= 1'b0;
      repeat (w) @(posedge clk);
    end
    start    <= 1'b1;
    pixel_in <= px;
    do @(posedge clk); while (busy);
    pixels_due.push_back(known ? want : convert_pixel(px));
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'($urandom_range(112, 127));
      1: f[30:23] = 8'($urandom_range(100, 126));
      2: f[30:23] = 8'd0;
      3: f[30:23] = 8'd255;
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) f[31] = 1'b0;
    return f;
  endfunction

  function automatic logic [srgb8_pkg::ColWidth-1:0] rand_col();
    logic [srgb8_pkg::ColWidth-1:0] c;
    c = srgb8_pkg::ColWidth'({$urandom(), $urandom()});
    if ($urandom_range(0, 2) != 0) begin
      for (int k = 0; k < 3; k++)
        c[k*18 +: 18] = 18'($signed($urandom_range(0, 20000)) - 3000);
    end
    return c;
  endfunction

  row_t directed [] = '{
    '{'{32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{32'h00000000, 32'h80000000, 32'h00000000, 32'h00000000}, 1'b1, '{0, 0, 0, 0}},
    '{'{32'h7f800000, 32'hff800000, 32'h7fc00000, 32'h7fffffff}, 1'b1, '{0, 0, 0, 0}},
    '{'{32'hbf800000, 32'hc2c80000, 32'hff7fffff, 32'hbf800000}, 1'b1, '{0, 0, 0, 0}},
    '{'{32'h7f7fffff, 32'h42c80000, 32'h40000000, 32'h7f7fffff}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255}},
    '{'{32'h00000001, 32'h007fffff, 32'h80000001, 32'h00000001}, 1'b1, '{0, 0, 0, 0}},
    '{'{32'h3f000000, 32'h3e800000, 32'h3d000000, 32'h3f000000}, 1'b0, '0},
    '{'{32'h3b4d2e1c, 32'h3b500000, 32'h3b480000, 32'h3e000000}, 1'b0, '0},
    '{'{32'h3a000000, 32'h3c000000, 32'h37800000, 32'h3f7fffff}, 1'b0, '0},
    '{'{32'h3f7fffff, 32'h3f400000, 32'h3ea00000, 32'h3b000000}, 1'b0, '0}
  };

  initial begin
    srgb8_pkg::pix_in_t px;
    rst = 1'b1;
    start = 1'b0;
    pixel_in = '0;
    cfg_valid = 1'b0;
    cfg_index = srgb8_pkg::RegColRed;
    cfg_data = '0;
    col_red = srgb8_pkg::ColRedReset;
    col_green = srgb8_pkg::ColGreenReset;
    col_blue = srgb8_pkg::ColBlueReset;
    lum_only = 1'b0;
    build_gamma_curve();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) send_pixel(directed[k].px, directed[k].known, directed[k].want, 0);
    wait_drained();
    write_reg(srgb8_pkg::RegLumOnly, 54'd1);
    for (int k = 0; k < 4; k++) send_pixel(directed[k+6].px, 0, '0, 0);
    wait_drained();
    write_reg(srgb8_pkg::RegColRed, {srgb8_pkg::ColWidth{1'b1}});
    write_reg(srgb8_pkg::RegColGreen, {18'h1ffff, 18'h20000, 18'h1ffff});
    write_reg(srgb8_pkg::RegColBlue, {18'h20000, 18'h1ffff, 18'h20000});
    write_reg(RegUnused, 54'h123);
    foreach (directed[k]) send_pixel(directed[k].px, 0, '0, 0);
    wait_drained();

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 250 == 0) begin
        wait_drained();
        write_reg(srgb8_pkg::RegColRed, rand_col());
        write_reg(srgb8_pkg::RegColGreen, rand_col());
        write_reg(srgb8_pkg::RegColBlue, rand_col());
        write_reg(srgb8_pkg::RegLumOnly, srgb8_pkg::ColWidth'($urandom_range(0, 1)));
      end
      px = '{rand_float(), rand_float(), rand_float(), rand_float()};
      if ($urandom_range(0, 19) == 0) px = {$urandom(), $urandom(), $urandom(), $urandom()};
      send_pixel(px, 0, '0, (n / 100) % 3 != 1);
    end
    wait_drained();
    if (mismatches == 0 && !timed_out) $display("[linear_to_srgb8_pixel_convert] OK");
    else $display("[linear_to_srgb8_pixel_convert] ERROR");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchLimit);
    timed_out = 1;
    $display("[linear_to_srgb8_pixel_convert] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/srgb8_pkg.sv
hw/rtl/srgb8_decode.sv
hw/rtl/srgb8_lane.sv
hw/rtl/linear_to_srgb8_pixel_convert.sv
sim/linear_to_srgb8_pixel_convert_tb.sv
